// File: rtl/core/multiset_hash_accumulator_defines.svh
// Assertion macros shared by the multiset hash accumulator RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef MULTISET_HASH_ACCUMULATOR_DEFINES_SVH
`define MULTISET_HASH_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSHA_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSHA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/core/msha_pkg.sv
// Package for the multiset hash accumulator: constants, word types, reduction.
// Depends on nothing; imported by every other file of the block but the assertion macros header.
`timescale 1ns / 1ps

package msha_pkg;

	// Modulus of the product aggregate, 2^32 - 5.
	localparam logic [31:0] MSHA_PRIME = 32'd4294967291;

	// Default depth of the queue between front and back.
	localparam int MSHA_QUEUE_DEPTH = 2;

	// Input word.
	typedef struct packed {
		logic        mode;
		logic        restart;
		logic [31:0] tuple_hash;
		logic [31:0] part_sum;
		logic [31:0] part_prod;
		logic [31:0] part_xor;
		logic [63:0] part_count;
	} item_t;

	// Result word.
	typedef struct packed {
		logic [31:0] agg_sum;
		logic [31:0] agg_prod;
		logic [31:0] agg_xor;
		logic [63:0] agg_count;
		logic        agg_empty;
	} result_t;

	// Classified operation handed from front to back.
	typedef struct packed {
		logic        restart;
		logic        skip;
		logic [31:0] s;
		logic [31:0] p;
		logic [31:0] x;
		logic [63:0] n;
	} op_t;

	// Queue status seen by front and back.
	typedef struct packed {
		logic not_full;
		logic not_empty;
	} q_status_t;

	// Reduce a 64-bit value modulo 2^32 - 5, using 2^32 = 5 (mod p).
	function automatic logic [31:0] mod_prime(input logic [63:0] x);
		logic [34:0] t;
		logic [32:0] u;
		logic [32:0] w;
		t = {3'b000, x[31:0]} + {1'b0, x[63:32], 2'b00} + {3'b000, x[63:32]};
		u = {1'b0, t[31:0]} + {28'd0, t[34:32], 2'b00} + {30'd0, t[34:32]};
		w = u - {1'b0, MSHA_PRIME};
		return (u >= {1'b0, MSHA_PRIME}) ? w[31:0] : u[31:0];
	endfunction

endpackage

// File: rtl/core/msha_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on msha_pkg for the payload types.
`timescale 1ns / 1ps

interface msha_item_if import msha_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface msha_result_if import msha_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/msha_front.sv
// Front end: accepts input words and classifies them into queue operations.
// Depends on msha_pkg and msha_item_if.
`timescale 1ns / 1ps

module msha_front import msha_pkg::*; (
	msha_item_if.sink item,
	input  q_status_t q_status,
	output logic      push,
	output op_t       push_op
);

	logic [31:0] hash_adj;

	// Accept whenever the queue has room.
	assign item.ready = q_status.not_full;
	assign push       = item.valid & q_status.not_full;

	// A hash of zero or of the prime is moved down by one, with wrap.
	always_comb begin
		hash_adj = item.data.tuple_hash;
		if ((item.data.tuple_hash == '0) || (item.data.tuple_hash == MSHA_PRIME)) begin
			hash_adj = item.data.tuple_hash - 32'd1;
		end
	end

	// Tuple words fold one hash; merge words fold a partial, skipped when its count is zero.
	always_comb begin
		push_op.restart = item.data.restart;
		if (item.data.mode) begin
			push_op.skip = (item.data.part_count == '0);
			push_op.s    = item.data.part_sum;
			push_op.p    = item.data.part_prod;
			push_op.x    = item.data.part_xor;
			push_op.n    = item.data.part_count;
		end else begin
			push_op.skip = 1'b0;
			push_op.s    = hash_adj;
			push_op.p    = hash_adj;
			push_op.x    = hash_adj;
			push_op.n    = 64'd1;
		end
	end

endmodule

// File: rtl/core/msha_fifo.sv
// Short queue of classified operations between front and back.
// Depends on msha_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "multiset_hash_accumulator_defines.svh"

module msha_fifo import msha_pkg::*; #(
	parameter int DEPTH = MSHA_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  op_t       push_op,
	input  logic      pop,
	output op_t       pop_op,
	output q_status_t status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.not_full  = (count_q != CNT_W'(DEPTH));
	assign status.not_empty = (count_q != '0);
	assign pop_op           = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill count never passes the depth.
	`MSHA_ASSERT_IMPL(a_count_bound, 1'b1, (count_q <= CNT_W'(DEPTH)), "queue overfilled")

endmodule

// File: rtl/core/msha_back.sv
// Back end: folds queued operations into the aggregate and registers the result.
// Depends on msha_pkg, msha_result_if and the assertion macros header.
`timescale 1ns / 1ps
`include "multiset_hash_accumulator_defines.svh"

module msha_back import msha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_status,
	input  op_t       op,
	output logic      pop,
	msha_result_if.source result
);

	logic [31:0] sum_q;
	logic [31:0] prod_q;
	logic [31:0] xor_q;
	logic [63:0] count_q;
	logic        res_valid_q;
	result_t     res_q;

	logic [63:0] base_cnt;
	logic        base_empty;
	logic [63:0] mul_full;
	logic [31:0] sum_nxt;
	logic [31:0] prod_nxt;
	logic [31:0] xor_nxt;
	logic [63:0] cnt_nxt;

	// Take an operation when the result slot is free or being emptied.
	assign pop = q_status.not_empty & (~res_valid_q | result.ready);

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// Restart empties the accumulator before the operation.
	assign base_cnt   = op.restart ? 64'd0 : count_q;
	assign base_empty = (base_cnt == '0);

	// One 32x32 multiply, then reduction modulo the prime.
	assign mul_full = 64'(prod_q) * 64'(op.p);

	// Next aggregate.
	always_comb begin
		if (op.skip) begin
			sum_nxt  = op.restart ? 32'd0 : sum_q;
			prod_nxt = op.restart ? 32'd0 : prod_q;
			xor_nxt  = op.restart ? 32'd0 : xor_q;
			cnt_nxt  = base_cnt;
		end else if (base_empty) begin
			sum_nxt  = op.s;
			prod_nxt = op.p;
			xor_nxt  = op.x;
			cnt_nxt  = op.n;
		end else begin
			sum_nxt  = sum_q + op.s;
			prod_nxt = mod_prime(mul_full);
			xor_nxt  = xor_q ^ op.x;
			cnt_nxt  = base_cnt + op.n;
		end
	end

	// Aggregate state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			prod_q  <= '0;
			xor_q   <= '0;
			count_q <= '0;
		end else if (pop) begin
			sum_q   <= sum_nxt;
			prod_q  <= prod_nxt;
			xor_q   <= xor_nxt;
			count_q <= cnt_nxt;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result word; an empty aggregate reports zeros.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_nxt == '0) begin
				res_q <= '{agg_sum: '0, agg_prod: '0, agg_xor: '0, agg_count: '0,
					agg_empty: 1'b1};
			end else begin
				res_q <= '{agg_sum: sum_nxt, agg_prod: prod_nxt, agg_xor: xor_nxt,
					agg_count: cnt_nxt, agg_empty: 1'b0};
			end
		end
	end

	// A combined product is fully reduced.
	`MSHA_ASSERT_NEXT(a_prod_reduced, (pop && !op.skip && !base_empty), (prod_q < MSHA_PRIME), "product not reduced")

	// The empty flag matches a zero count.
	`MSHA_ASSERT_IMPL(a_empty_flag, res_valid_q, (res_q.agg_empty == (res_q.agg_count == '0)), "empty flag mismatch")

	// An empty result carries zero aggregates.
	`MSHA_ASSERT_IMPL(a_empty_zero, (res_valid_q && res_q.agg_empty), ((res_q.agg_sum == '0) && (res_q.agg_prod == '0) && (res_q.agg_xor == '0)), "empty result not zero")

endmodule

// File: rtl/core/multiset_hash_accumulator.sv
// Multiset hash accumulator: order-independent sum, product mod 2^32-5, xor and count.
// Usage: feed words on item, take running aggregates on result (one result per word).
// Channels: item carries a tuple hash (mode 0) or a partial aggregate (mode 1) and a
// restart flag; result carries sum, product, xor, 64-bit count and an empty flag.
// Path: a word accepted on item is written into the queue, then the back end pops it
// from the queue and registers the fold into the aggregate and the result word.
// Throughput: one word per cycle while the receiver takes results. The loop that sets it
// is the product register: one 32x32 multiply and a constant fold modulo the prime, both combinational.
// Reset clears the aggregate to empty, the queue and the result valid flag.
// When the receiver stalls, the result word holds and the back end stops; the queue
// keeps taking words until it is full (QUEUE_DEPTH words), then item.ready falls.
// Depends on msha_pkg, msha_if, msha_front, msha_fifo and msha_back.
`timescale 1ns / 1ps

module multiset_hash_accumulator import msha_pkg::*; #(
	parameter int QUEUE_DEPTH = MSHA_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	msha_item_if.sink     item,
	msha_result_if.source result
);

	q_status_t q_status;
	logic      push;
	op_t       push_op;
	logic      pop;
	op_t       pop_op;

	// Input classification.
	msha_front u_front (
		.item     (item),
		.q_status (q_status),
		.push     (push),
		.push_op  (push_op)
	);

	// Decoupling queue.
	msha_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.status  (q_status)
	);

	// Aggregate update and result register.
	msha_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.op       (pop_op),
		.pop      (pop),
		.result   (result)
	);

endmodule
